/* design/rpu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared widths, codes, reset values and stage payload types of the
// iRprop+ update engine.
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STEP_W    = 31;
  localparam int ETA_W     = 16;
  localparam int ETA_FRAC  = 14;
  localparam int PROD_W    = STEP_W + ETA_W;
  localparam int SCALED_W  = PROD_W - ETA_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic [ETA_W-1:0]  ETA_INCREASE_RST = 16'd19661;
  localparam logic [ETA_W-1:0]  ETA_DECREASE_RST = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_MAX_RST     = 31'd3276800;
  localparam logic [STEP_W-1:0] STEP_MIN_RST     = 31'd1;
  localparam logic [STEP_W-1:0] STEP_INITIAL_RST = 31'd6554;

  localparam logic [CFG_IDX_W-1:0] CFG_ETA_INCREASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_DECREASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INITIAL = 3'd4;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'b00,
    SIGN_POS  = 2'b01,
    SIGN_NEG  = 2'b10
  } sign_t;

  typedef enum logic [1:0] {
    CLS_HOLD   = 2'b00,
    CLS_GROW   = 2'b01,
    CLS_SHRINK = 2'b10
  } cls_t;

  typedef struct packed {
    logic [ETA_W-1:0]  eta_increase;
    logic [ETA_W-1:0]  eta_decrease;
    logic [STEP_W-1:0] step_max;
    logic [STEP_W-1:0] step_min;
    logic [STEP_W-1:0] step_initial;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] grad;
    logic                    err_up;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]       step;
    sign_t                   sign;
    logic signed [VAL_W-1:0] last_update;
  } state_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    in_range;
    logic signed [VAL_W-1:0] value;
    sign_t                   gsign;
    cls_t                    cls;
    logic [STEP_W-1:0]       step_old;
    logic signed [VAL_W-1:0] last_update;
    logic                    err_up;
    logic [PROD_W-1:0]       product;
  } scale_stage_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] update;
    logic [STEP_W-1:0]       step;
  } apply_stage_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_param;
    logic [STEP_W-1:0]       step_size;
  } out_item_t;

endpackage
`default_nettype wire

/* design/rprop_plus_update_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rprop_plus_update_engine
// iRprop+ step-size and parameter update, one element per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries elem_index, param_value,
//   gradient and error_increased. Output channel (out_valid/out_ready)
//   returns new_param and step_size, one result per input, in order.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
//   Pipeline: a result passes through the input register, state read and
//   scaling multiply, step bound and state write-back, value add and
//   saturation, and the output register before it is presented.
//   Throughput: one transaction per cycle while out_ready is high. Two
//   back-to-back transactions on the same element insert a bubble: the
//   second waits until the first has bounded its new step and written it back.
//   Reset clears the pipeline valid bits, the per-element valid bits and
//   loads the register defaults; state memory needs no clearing pass.
//   When out_ready is low, the output register holds its result and the
//   stages behind it fill up; in_ready drops once all are full.
// ----------------------------------------------------------------------------
module rprop_plus_update_engine import rpu_pkg::*; #(
  parameter int NUM_ELEMENTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [STEP_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IDX_W-1:0]        elem_index,
  input  logic signed [VAL_W-1:0] param_value,
  input  logic signed [VAL_W-1:0] gradient,
  input  logic                    error_increased,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] new_param,
  output logic [STEP_W-1:0]       step_size
);

  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int DEPTH    = (NUM_ELEMENTS < IDX_SPAN) ? NUM_ELEMENTS : IDX_SPAN;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(DEPTH);
  localparam int ENTRY_W  = $bits(state_entry_t);

  cfg_t cfg;

  logic         s1_valid;
  in_item_t     s1_item;
  logic         s2_valid;
  in_item_t     s2_item;
  logic         s3_valid;
  scale_stage_t s3;
  logic         s4_valid;
  apply_stage_t s4;
  out_item_t    out_item;

  logic         o_free;
  logic         s4_free;
  logic         s3_free;
  logic         s3_adv;
  logic         s2_free;
  logic         s1_free;
  logic         s1_adv;
  logic         hazard;

  logic [AW+IDX_W-1:0] s1_ext;
  logic [AW+IDX_W-1:0] s2_ext;
  logic [AW+IDX_W-1:0] s3_ext;
  logic [AW-1:0]       s1_addr;
  logic [AW-1:0]       s2_addr;
  logic [AW-1:0]       s3_addr;
  logic [AW-1:0]       raddr;
  logic                s2_in_range;

  logic [DEPTH-1:0]    entry_valid;
  logic                mem_we;
  logic [ENTRY_W-1:0]  rdata;
  state_entry_t        mem_entry;
  state_entry_t        wr_entry;

  logic                lw_valid;
  logic [AW-1:0]       lw_addr;
  state_entry_t        lw_entry;
  logic                fwd_hit;

  scale_stage_t        s3_next;
  apply_stage_t        s4_next;
  out_item_t           out_next;

  always_comb begin
    s1_ext  = (AW + IDX_W)'(s1_item.idx);
    s2_ext  = (AW + IDX_W)'(s2_item.idx);
    s3_ext  = (AW + IDX_W)'(s3.idx);
    s1_addr = s1_ext[AW-1:0];
    s2_addr = s2_ext[AW-1:0];
    s3_addr = s3_ext[AW-1:0];
    s2_in_range = {1'b0, s2_item.idx} < DEPTH_L;
  end

  assign hazard  = s2_valid && s2_in_range && s3_valid && s3.in_range && s2_item.idx == s3.idx;
  assign o_free  = !out_valid || out_ready;
  assign s4_free = !s4_valid || o_free;
  assign s3_free = !s3_valid || s4_free;
  assign s3_adv  = s3_valid && s4_free;
  assign s2_free = !s2_valid || (s3_free && !hazard);
  assign s1_free = !s1_valid || s2_free;
  assign s1_adv  = s1_valid && s2_free;
  assign in_ready = s1_free;

  assign raddr   = s1_adv ? s1_addr : s2_addr;
  assign mem_we  = s3_adv && s3.in_range;
  assign mem_entry = state_entry_t'(rdata);
  assign fwd_hit = lw_valid && lw_addr == s2_addr;

  rpu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s3_addr),
    .wdata (ENTRY_W'(wr_entry)),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpu_decode u_decode (
    .item        (s2_item),
    .in_range    (s2_in_range),
    .entry_valid (entry_valid[s2_addr]),
    .mem_entry   (mem_entry),
    .fwd_entry   (lw_entry),
    .fwd_hit     (fwd_hit),
    .cfg         (cfg),
    .stage       (s3_next)
  );

  rpu_step_calc u_step_calc (
    .stage    (s3),
    .cfg      (cfg),
    .next     (s4_next),
    .wr_entry (wr_entry)
  );

  rpu_apply u_apply (
    .stage  (s4),
    .result (out_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eta_increase <= ETA_INCREASE_RST;
      cfg.eta_decrease <= ETA_DECREASE_RST;
      cfg.step_max     <= STEP_MAX_RST;
      cfg.step_min     <= STEP_MIN_RST;
      cfg.step_initial <= STEP_INITIAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ETA_INCREASE: cfg.eta_increase <= cfg_data[ETA_W-1:0];
        CFG_ETA_DECREASE: cfg.eta_decrease <= cfg_data[ETA_W-1:0];
        CFG_STEP_MAX:     cfg.step_max     <= cfg_data;
        CFG_STEP_MIN:     cfg.step_min     <= cfg_data;
        CFG_STEP_INITIAL: cfg.step_initial <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      out_valid   <= 1'b0;
      lw_valid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid && !hazard;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (o_free) begin
        out_valid <= s4_valid;
      end
      lw_valid <= mem_we;
      if (mem_we) begin
        entry_valid[s3_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_item.idx    <= elem_index;
      s1_item.value  <= param_value;
      s1_item.grad   <= gradient;
      s1_item.err_up <= error_increased;
    end
    if (s1_adv) begin
      s2_item <= s1_item;
    end
    if (s3_free) begin
      s3 <= s3_next;
    end
    if (s4_free) begin
      s4 <= s4_next;
    end
    if (o_free) begin
      out_item <= out_next;
    end
    lw_addr  <= s3_addr;
    lw_entry <= wr_entry;
  end

  assign new_param = out_item.new_param;
  assign step_size = out_item.step_size;

endmodule
`default_nettype wire

/* design/rpu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/rpu_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_decode
// Select the element state, classify the gradient sign against the stored
// sign and scale the step by the chosen factor.
// ----------------------------------------------------------------------------
module rpu_decode import rpu_pkg::*; (
  input  in_item_t     item,
  input  logic         in_range,
  input  logic         entry_valid,
  input  state_entry_t mem_entry,
  input  state_entry_t fwd_entry,
  input  logic         fwd_hit,
  input  cfg_t         cfg,
  output scale_stage_t stage
);

  state_entry_t      state;
  sign_t             gsign;
  sign_t             prev_sign;
  cls_t              cls;
  logic [STEP_W-1:0] step_old;
  logic [ETA_W-1:0]  eta;

  always_comb begin
    state = fwd_hit ? fwd_entry : mem_entry;

    if (item.grad == '0) begin
      gsign = SIGN_ZERO;
    end else if (item.grad[VAL_W-1]) begin
      gsign = SIGN_NEG;
    end else begin
      gsign = SIGN_POS;
    end

    if (entry_valid) begin
      step_old  = state.step;
      prev_sign = state.sign;
    end else begin
      step_old  = cfg.step_initial;
      prev_sign = SIGN_ZERO;
    end

    if (gsign == SIGN_ZERO || prev_sign == SIGN_ZERO) begin
      cls = CLS_HOLD;
    end else if (gsign == prev_sign) begin
      cls = CLS_GROW;
    end else begin
      cls = CLS_SHRINK;
    end

    eta = (cls == CLS_GROW) ? cfg.eta_increase : cfg.eta_decrease;

    stage.idx         = item.idx;
    stage.in_range    = in_range;
    stage.value       = item.value;
    stage.gsign       = gsign;
    stage.cls         = cls;
    stage.step_old    = step_old;
    stage.last_update = entry_valid ? state.last_update : '0;
    stage.err_up      = item.err_up;
    stage.product     = PROD_W'(step_old) * PROD_W'(eta);
  end

endmodule
`default_nettype wire

/* design/rpu_step_calc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_step_calc
// Bound the scaled step, pick the update and form the new element state.
// ----------------------------------------------------------------------------
module rpu_step_calc import rpu_pkg::*; (
  input  scale_stage_t stage,
  input  cfg_t         cfg,
  output apply_stage_t next,
  output state_entry_t wr_entry
);

  logic [SCALED_W-1:0]     scaled;
  logic [SCALED_W-1:0]     floored;
  logic [STEP_W-1:0]       step_new;
  sign_t                   sign_new;
  logic signed [VAL_W-1:0] step_ext;
  logic signed [VAL_W-1:0] update;

  always_comb begin
    scaled  = stage.product[PROD_W-1:ETA_FRAC];
    floored = (scaled < SCALED_W'(cfg.step_min)) ? SCALED_W'(cfg.step_min) : scaled;

    unique case (stage.cls)
      CLS_GROW: begin
        step_new = (scaled > SCALED_W'(cfg.step_max)) ? cfg.step_max : scaled[STEP_W-1:0];
        sign_new = stage.gsign;
      end
      CLS_SHRINK: begin
        step_new = (|floored[SCALED_W-1:STEP_W]) ? '1 : floored[STEP_W-1:0];
        sign_new = SIGN_ZERO;
      end
      default: begin
        step_new = stage.step_old;
        sign_new = stage.gsign;
      end
    endcase

    step_ext = VAL_W'(step_new);

    if (stage.cls == CLS_SHRINK) begin
      update = stage.err_up ? -stage.last_update : '0;
    end else begin
      unique case (stage.gsign)
        SIGN_POS: update = -step_ext;
        SIGN_NEG: update = step_ext;
        default:  update = '0;
      endcase
    end

    wr_entry.step        = step_new;
    wr_entry.sign        = sign_new;
    wr_entry.last_update = update;

    next.value  = stage.value;
    next.update = stage.in_range ? update : '0;
    next.step   = stage.in_range ? step_new : '0;
  end

endmodule
`default_nettype wire

/* design/rpu_apply.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_apply
// Add the update to the parameter value and saturate to 32 bits.
// ----------------------------------------------------------------------------
module rpu_apply import rpu_pkg::*; (
  input  apply_stage_t stage,
  output out_item_t    result
);

  logic signed [VAL_W:0] sum;

  always_comb begin
    sum = {stage.value[VAL_W-1], stage.value} + {stage.update[VAL_W-1], stage.update};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      result.new_param = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      result.new_param = sum[VAL_W-1:0];
    end
    result.step_size = stage.step;
  end

endmodule
`default_nettype wire

/* design/rpu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpu_checker
// Port-level checks of the update engine, bound to the top level.
// ----------------------------------------------------------------------------
module rpu_checker import rpu_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [IDX_W-1:0]        elem_index,
  input logic signed [VAL_W-1:0] param_value,
  input logic signed [VAL_W-1:0] gradient,
  input logic                    error_increased,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] new_param,
  input logic [STEP_W-1:0]       step_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_param) && $stable(step_size))
    else $error("stalled result changed or dropped");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(elem_index) && $stable(param_value)
      && $stable(gradient) && $stable(error_increased))
    else $error("waiting input transaction changed or withdrawn");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result appeared sooner than the pipeline latency after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind rprop_plus_update_engine rpu_checker u_rpu_checker (.*);
`default_nettype wire

/* dv/tb_rprop_plus_update_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rprop_plus_update_engine
// Self-checking bench for the iRprop+ update engine. A short table of
// directed elements runs at the reset settings, then randomized phases
// stream elements under several register settings, from the extremes to
// random ones. Both channels idle at random outside one quiet phase; one
// phase stalls the output long enough to back up the input. Each result is
// checked in order against its table row or a model of step, sign and last update.
// ----------------------------------------------------------------------------
module tb_rprop_plus_update_engine;
  import rpu_pkg::*;

  localparam int DIR_N       = 16;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 315;
  localparam int IDLE_PCT    = 34;
  localparam int HOLD_CYCLES = 60;
  localparam int END_CYCLES  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] grad;
    logic                    err_up;
    logic                    given;
    out_item_t               result;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [STEP_W-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [IDX_W-1:0]        elem_index = '0;
  logic signed [VAL_W-1:0] param_value = '0;
  logic signed [VAL_W-1:0] gradient = '0;
  logic                    error_increased = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] new_param;
  logic [STEP_W-1:0]       step_size;

  logic                    row_given = 1'b0;
  out_item_t               row_result = '0;

  bit quiet_phase = 1'b0;
  bit pressure_phase = 1'b0;

  cfg_t                    model_cfg;
  logic [STEP_W-1:0]       elem_step [64];
  sign_t                   elem_sign [64];
  logic signed [VAL_W-1:0] elem_last_upd [64];
  bit                      elem_seen [64];

  out_item_t pending_results [$];
  dir_row_t  dir_table [DIR_N];

  int err_count = 0;
  int cycles = 0;
  int accepted = 0;
  int checked = 0;
  int input_stalls = 0;
  int n_grow = 0, n_shrink = 0, n_revert = 0, n_zero = 0, n_first = 0;

  rprop_plus_update_engine dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .elem_index      (elem_index),
    .param_value     (param_value),
    .gradient        (gradient),
    .error_increased (error_increased),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .new_param       (new_param),
    .step_size       (step_size)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic out_item_t rprop_update(input logic [IDX_W-1:0] idx,
                                             input logic signed [VAL_W-1:0] value,
                                             input logic signed [VAL_W-1:0] grad,
                                             input logic err_up);
    sign_t     gs, ps;
    cls_t      cls;
    longint    step, scaled, upd;
    out_item_t res;
    gs = (grad > 0) ? SIGN_POS : ((grad < 0) ? SIGN_NEG : SIGN_ZERO);
    step = elem_seen[idx] ? longint'(elem_step[idx]) : longint'(model_cfg.step_initial);
    ps = elem_seen[idx] ? elem_sign[idx] : SIGN_ZERO;
    if (!elem_seen[idx]) n_first++;
    if (gs == SIGN_ZERO) n_zero++;
    if (gs != SIGN_ZERO && gs == ps) cls = CLS_GROW;
    else if (gs != SIGN_ZERO && ps != SIGN_ZERO) cls = CLS_SHRINK;
    else cls = CLS_HOLD;
    case (cls)
      CLS_GROW: begin
        n_grow++;
        scaled = (step * longint'(model_cfg.eta_increase)) >> ETA_FRAC;
        if (scaled > longint'(model_cfg.step_max)) scaled = longint'(model_cfg.step_max);
        step = scaled;
        upd = (gs == SIGN_POS) ? -step : step;
      end
      CLS_SHRINK: begin
        n_shrink++;
        scaled = (step * longint'(model_cfg.eta_decrease)) >> ETA_FRAC;
        if (scaled < longint'(model_cfg.step_min)) scaled = longint'(model_cfg.step_min);
        if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
        step = scaled;
        if (err_up) n_revert++;
        upd = err_up ? -longint'(elem_last_upd[idx]) : 64'sd0;
      end
      default: begin
        upd = (gs == SIGN_POS) ? -step : ((gs == SIGN_NEG) ? step : 64'sd0);
      end
    endcase
    res.new_param = VAL_W'(sat32(longint'(value) + upd));
    res.step_size = STEP_W'(step);
    elem_step[idx] = STEP_W'(step);
    elem_sign[idx] = (cls == CLS_SHRINK) ? SIGN_ZERO : gs;
    elem_last_upd[idx] = VAL_W'(sat32(upd));
    elem_seen[idx] = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    out_item_t predicted, want;
    if (rst) begin
      model_cfg = '{ETA_INCREASE_RST, ETA_DECREASE_RST, STEP_MAX_RST, STEP_MIN_RST,
                    STEP_INITIAL_RST};
      for (int k = 0; k < 64; k++) elem_seen[k] = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ETA_INCREASE: model_cfg.eta_increase = cfg_data[ETA_W-1:0];
          CFG_ETA_DECREASE: model_cfg.eta_decrease = cfg_data[ETA_W-1:0];
          CFG_STEP_MAX:     model_cfg.step_max = cfg_data;
          CFG_STEP_MIN:     model_cfg.step_min = cfg_data;
          CFG_STEP_INITIAL: model_cfg.step_initial = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_ready) input_stalls++;
      if (in_valid && in_ready) begin
        predicted = rprop_update(elem_index, param_value, gradient, error_increased);
        pending_results.insert(pending_results.size(), row_given ? row_result : predicted);
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with no transaction outstanding", checked));
        end else begin
          want = pending_results.pop_front();
          if (new_param !== want.new_param)
            report_mismatch($sformatf("result %0d new_param %0d, expected %0d", checked,
                                      new_param, want.new_param));
          if (step_size !== want.step_size)
            report_mismatch($sformatf("result %0d step_size %0d, expected %0d", checked,
                                      step_size, want.step_size));
        end
        checked++;
      end
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (pressure_phase && !held) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        held = 1'b1;
      end else if (quiet_phase) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer_item(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] value,
                            input logic signed [VAL_W-1:0] grad, input logic err_up,
                            input logic given, input out_item_t result);
    if (!quiet_phase) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    elem_index      <= idx;
    param_value     <= value;
    gradient        <= grad;
    error_increased <= err_up;
    row_given       <= given;
    row_result      <= result;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [STEP_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_registers(input cfg_t c);
    write_reg(CFG_ETA_INCREASE, STEP_W'(c.eta_increase));
    write_reg(CFG_ETA_DECREASE, STEP_W'(c.eta_decrease));
    write_reg(CFG_STEP_MAX, c.step_max);
    write_reg(CFG_STEP_MIN, c.step_min);
    write_reg(CFG_STEP_INITIAL, c.step_initial);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t                    c;
    dir_row_t                row;
    logic [IDX_W-1:0]        idx, last_idx;
    logic [IDX_W-1:0]        hot_base;
    logic signed [VAL_W-1:0] value, grad;
    logic [VAL_W-1:0]        mag;
    int                      stim_dir [64];
    int                      r;

    dir_table = '{
      '{6'd0,  32'sd0,          32'sd5,          1'b0, 1'b1, '{-32'sd6554, 31'd6554}},
      '{6'd0,  -32'sd6554,      32'sd1,          1'b0, 1'b0, '0},
      '{6'd0,  -32'sd14418,     -32'sd3,         1'b1, 1'b0, '0},
      '{6'd0,  -32'sd6554,      32'sd0,          1'b0, 1'b0, '0},
      '{6'd0,  32'sd100,        -32'sd7,         1'b0, 1'b0, '0},
      '{6'd1,  32'sh7FFF_FFFF,  -32'sd1,         1'b0, 1'b1, '{32'sh7FFF_FFFF, 31'd6554}},
      '{6'd2,  32'sh8000_0000,  32'sh7FFF_FFFF,  1'b1, 1'b1, '{32'sh8000_0000, 31'd6554}},
      '{6'd3,  32'sd12345,      32'sd0,          1'b1, 1'b1, '{32'sd12345, 31'd6554}},
      '{6'd63, 32'sd0,          32'sh8000_0000,  1'b1, 1'b1, '{32'sd6554, 31'd6554}},
      '{6'd1,  32'sd0,          -32'sd9,         1'b0, 1'b0, '0},
      '{6'd1,  32'sd5000,       32'sd9,          1'b0, 1'b0, '0},
      '{6'd1,  32'sd5000,       32'sd9,          1'b1, 1'b0, '0},
      '{6'd2,  32'sh8000_0000,  -32'sd1,         1'b1, 1'b0, '0},
      '{6'd42, 32'sh5555_5555,  32'sh2AAA_AAAA,  1'b0, 1'b1, '{32'sd1431649211, 31'd6554}},
      '{6'd21, 32'shAAAA_AAAA,  -32'sd1,         1'b1, 1'b0, '0},
      '{6'd63, 32'sd0,          32'sd1,          1'b1, 1'b0, '0}
    };
    for (int k = 0; k < 64; k++) stim_dir[k] = 1;
    last_idx = '0;
    hot_base = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      row = dir_table[i];
      offer_item(row.idx, row.value, row.grad, row.err_up, row.given, row.result);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: c = '{16'hFFFF, 16'h0000, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF};
        1: c = '{16'h0000, 16'hFFFF, 31'd1, 31'h7FFF_FFFF, 31'd1};
        2: c = '{ETA_INCREASE_RST, ETA_DECREASE_RST, STEP_MAX_RST, STEP_MIN_RST,
                 STEP_INITIAL_RST};
        5: c = '{16'd24576, 16'd4096, 31'd65536000, 31'd16, 31'd65536};
        default: begin
          c.eta_increase = 16'($urandom_range(0, 65535));
          c.eta_decrease = 16'($urandom_range(0, 65535));
          c.step_max     = STEP_W'(($urandom() >> $urandom_range(1, 20)) | 32'd1);
          c.step_min     = STEP_W'($urandom() >> $urandom_range(8, 31));
          c.step_initial = STEP_W'(($urandom() >> $urandom_range(4, 28)) | 32'd1);
        end
      endcase
      load_registers(c);
      quiet_phase = (p == 2);
      pressure_phase = (p == 3);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) idx = last_idx;
        else if (r < 65) idx = hot_base + IDX_W'($urandom_range(0, 3));
        else idx = IDX_W'($urandom_range(0, 63));
        if ($urandom_range(0, 49) == 0) hot_base = IDX_W'($urandom_range(0, 63));
        last_idx = idx;

        r = $urandom_range(0, 99);
        if (r < 15) begin
          grad = '0;
        end else begin
          if (r < 35) stim_dir[idx] = -stim_dir[idx];
          mag = ($urandom() >> $urandom_range(1, 31)) | 32'd1;
          if ($urandom_range(0, 9) == 0)
            grad = (stim_dir[idx] > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          else if ($urandom_range(0, 9) == 0)
            grad = (stim_dir[idx] > 0) ? 32'sd1 : -32'sd1;
          else
            grad = (stim_dir[idx] > 0) ? $signed(mag) : $signed(~mag);
        end

        r = $urandom_range(0, 99);
        if (r < 70) value = $signed($urandom());
        else if (r < 85) value = 32'sh7FFF_FFFF - $signed($urandom_range(0, 70000));
        else value = 32'sh8000_0000 + $signed($urandom_range(0, 70000));

        offer_item(idx, value, grad, 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      drain();
    end

    quiet_phase = 1'b0;
    pressure_phase = 1'b0;
    repeat (END_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));

    $display("Covered %0d transactions and %0d results over %0d register settings.",
             accepted, checked, NUM_PHASES + 1);
    $display("Grow %0d, shrink %0d (revert %0d), zero gradient %0d, first visit %0d,",
             n_grow, n_shrink, n_revert, n_zero, n_first);
    $display("%0d input stall cycles.", input_stalls);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
